// ----- rtl/lcls_pkg.sv -----
// Package for the card number Luhn classifier.
// Holds the sequencer state type, sizes and brand codes; no dependencies.

package lcls_pkg;

  // Input word and its decimal image
  localparam int unsigned NUM_BITS   = 63;
  localparam int unsigned NUM_DIGITS = 19;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;

  // Brand codes on card_kind
  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_AMEX    = 2'd1;
  localparam logic [1:0] KIND_MASTER  = 2'd2;
  localparam logic [1:0] KIND_VISA    = 2'd3;

  // Valid lengths in digits
  localparam logic [4:0] LEN_SHORT = 5'd13;
  localparam logic [4:0] LEN_MID   = 5'd15;
  localparam logic [4:0] LEN_LONG  = 5'd16;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ----- rtl/lcls_bcd_step.sv -----
// One shift-and-add-3 step of the binary to BCD conversion.
// Depends on lcls_pkg for the BCD width.

module lcls_bcd_step
  import lcls_pkg::*;
(
  input  logic [BCD_W-1:0] bcd_in,
  input  logic             bit_in,
  output logic [BCD_W-1:0] bcd_out
);

  logic [BCD_W-1:0] adj;

  // Add 3 to every digit of 5 or more, then shift the next binary bit in
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_in[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_in[4*i +: 4];
      end
    end
    bcd_out = {adj[BCD_W-2:0], bit_in};
  end

endmodule

// ----- rtl/card_number_luhn_classifier_unit.sv -----
// Card number Luhn classifier: 63-bit binary in, brand, Luhn flag and digit count out.
// Each number goes through 63 conversion steps, then 19 digit scan steps, then a load of
// the output register. A new number is accepted only after the previous result is loaded.
// The conversion is paced by the shared BCD shift unit taking one input bit a cycle.
// in_tready is high only when idle, and a stalled result holds the sequencer in its
// last state until the output register frees.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_tvalid.
// Uses lcls_pkg and lcls_bcd_step.

module card_number_luhn_classifier_unit
  import lcls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [62:0] card_number, [63] zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] card_kind, [2] luhn_ok, [7:3] digit_count
);

  state_t             state_r, state_nxt;
  logic [NUM_BITS-1:0] num_r, num_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt, bcd_step;
  logic [5:0]         idx_r, idx_nxt;
  logic [3:0]         sum_r, sum_nxt;
  logic [4:0]         count_r, count_nxt;
  logic [3:0]         lead_r, lead_nxt;
  logic [3:0]         second_r, second_nxt;
  logic [3:0]         prev_r, prev_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;

  logic [3:0] digit;
  logic [4:0] dbl;
  logic [3:0] weight;
  logic [4:0] acc;
  logic       ok;
  logic       len_ok;
  logic [1:0] kind;
  logic       out_free;

  lcls_bcd_step u_step (
    .bcd_in  (bcd_r),
    .bit_in  (num_r[NUM_BITS-1]),
    .bcd_out (bcd_step)
  );

  // Luhn weight of the digit under scan, running sum kept modulo ten
  always_comb begin
    digit = bcd_r[3:0];
    dbl   = {digit, 1'b0};
    if (idx_r[0]) begin
      weight = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
    end else begin
      weight = digit;
    end
    acc = {1'b0, sum_r} + {1'b0, weight};
  end

  // Classify once the scan is finished
  always_comb begin
    ok     = (sum_r == 4'd0);
    len_ok = (count_r == LEN_SHORT) || (count_r == LEN_MID) || (count_r == LEN_LONG);
    kind   = KIND_INVALID;
    if (ok && len_ok) begin
      priority if (lead_r == 4'd3 && (second_r == 4'd4 || second_r == 4'd7)) begin
        kind = KIND_AMEX;
      end else if (lead_r == 4'd5 && second_r >= 4'd1 && second_r <= 4'd5) begin
        kind = KIND_MASTER;
      end else if (lead_r == 4'd4) begin
        kind = KIND_VISA;
      end else begin
        kind = KIND_INVALID;
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequencer: convert, scan digits, hand result to the output register
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    bcd_nxt       = bcd_r;
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    lead_nxt      = lead_r;
    second_nxt    = second_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          num_nxt   = in_tdata[NUM_BITS-1:0];
          bcd_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = bcd_step;
        num_nxt = {num_r[NUM_BITS-2:0], 1'b0};
        if (idx_r == 6'(NUM_BITS - 1)) begin
          idx_nxt    = '0;
          sum_nxt    = '0;
          count_nxt  = '0;
          lead_nxt   = '0;
          second_nxt = '0;
          prev_nxt   = '0;
          state_nxt  = S_SCAN;
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
      end
      S_SCAN: begin
        sum_nxt  = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
        prev_nxt = digit;
        if (digit != 4'd0) begin
          count_nxt  = 5'(idx_r + 6'd1);
          lead_nxt   = digit;
          second_nxt = prev_r;
        end
        bcd_nxt = {4'd0, bcd_r[BCD_W-1:4]};
        if (idx_r == 6'(NUM_DIGITS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 6'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {count_r, ok, kind};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Advance datapath registers
  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    bcd_r      <= bcd_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    count_r    <= count_nxt;
    lead_r     <= lead_nxt;
    second_r   <= second_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
